/* hw/rtl/bpve_pkg.sv */
// Package for the BACnet primitive value encoder.
// Holds the value kind codes, the tag and class constants and the encoded word record.
// No dependencies.
`default_nettype none

package bpve_pkg;

	typedef enum logic [3:0] {
		ACT_NULL     = 4'd0,
		ACT_BOOL     = 4'd1,
		ACT_UNS      = 4'd2,
		ACT_ENUM     = 4'd3,
		ACT_SGN      = 4'd4,
		ACT_REAL     = 4'd5,
		ACT_DBL      = 4'd6,
		ACT_DATE     = 4'd7,
		ACT_TIME     = 4'd8,
		ACT_OID      = 4'd9,
		ACT_CTX_UNS  = 4'd10,
		ACT_CTX_ENUM = 4'd11,
		ACT_CTX_SGN  = 4'd12,
		ACT_CTX_BOOL = 4'd13,
		ACT_OPEN     = 4'd14,
		ACT_CLOSE    = 4'd15
	} action_t;

	// Application tag numbers
	localparam logic [7:0] TAG_NULL = 8'd0;
	localparam logic [7:0] TAG_BOOL = 8'd1;
	localparam logic [7:0] TAG_UNS  = 8'd2;
	localparam logic [7:0] TAG_SGN  = 8'd3;
	localparam logic [7:0] TAG_REAL = 8'd4;
	localparam logic [7:0] TAG_DBL  = 8'd5;
	localparam logic [7:0] TAG_ENUM = 8'd9;
	localparam logic [7:0] TAG_DATE = 8'd10;
	localparam logic [7:0] TAG_TIME = 8'd11;
	localparam logic [7:0] TAG_OID  = 8'd12;

	localparam logic [7:0] TAG_EXT_MIN  = 8'd15;
	localparam logic [7:0] TAG_REFUSED  = 8'd255;
	localparam logic [7:0] HDR_EXT_TAG  = 8'hF0;
	localparam logic [7:0] CLASS_CTX    = 8'h08;
	localparam logic [2:0] LEN_EXT      = 3'd5;
	localparam logic [2:0] MARK_OPEN    = 3'd6;
	localparam logic [2:0] MARK_CLOSE   = 3'd7;

	localparam logic [31:0] REAL_INF    = 32'h7F80_0000;
	localparam logic [62:0] DBL_INF     = 63'h7FF0_0000_0000_0000;
	localparam logic [15:0] YEAR_BASE   = 16'd1900;
	localparam logic [15:0] YEAR_MAX    = 16'd2154;
	localparam logic [15:0] YEAR_ANY    = 16'hFFFF;
	localparam logic [7:0]  FIELD_ANY   = 8'hFF;
	localparam logic [15:0] OTYPE_MAX   = 16'd1023;

	localparam int QUEUE_DEPTH_DEF = 2;

	// One encoded value as it travels from the front end to the serialiser
	typedef struct packed {
		logic             err;
		logic [3:0]       total;
		logic [1:0]       hlen;
		logic [2:0][7:0]  hdr;
		logic [7:0][7:0]  body;
	} rec_t;

endpackage

`default_nettype wire

/* hw/rtl/bpve_front.sv */
// Front end of the BACnet primitive value encoder: checks and classifies one value.
// Builds the tag header and content octets into a record. Depends on bpve_pkg.
`default_nettype none

module bpve_front import bpve_pkg::*; (
	input  wire logic [3:0]  action,
	input  wire logic [7:0]  tag_number,
	input  wire logic [63:0] value,
	input  wire logic [15:0] object_type,
	input  wire logic [15:0] year,
	input  wire logic [7:0]  byte_a,
	input  wire logic [7:0]  byte_b,
	input  wire logic [7:0]  byte_c,
	input  wire logic [7:0]  byte_d,
	input  wire logic [7:0]  room,
	output rec_t             rec
);

	logic [31:0]      lo;
	logic             sgn;
	logic [31:0]      mag;
	logic [2:0]       ilen;
	logic [7:0][7:0]  ibody;
	logic [7:0]       tag;
	logic [7:0]       cls;
	logic             use_mark;
	logic [2:0]       mark;
	logic [3:0]       clen;
	logic [7:0][7:0]  body;
	logic             bad;
	logic             ext_tag;
	logic             ext_len;
	logic [2:0]       low3;
	logic [7:0]       h0;
	logic [1:0]       hlen;
	logic [3:0]       total;
	logic [31:0]      oid_word;
	logic [7:0]       year_byte;
	logic             lo_nz;

	assign lo = value[31:0];
	assign lo_nz = (lo != 32'd0);
	assign sgn = (action_t'(action) == ACT_SGN) || (action_t'(action) == ACT_CTX_SGN);

	// Minimal integer length: signed values keep one spare bit for the sign.
	always_comb begin
		mag = (sgn && lo[31]) ? ~lo : lo;
		if (sgn) begin
			if (mag[31:23] != 9'd0)
				ilen = 3'd4;
			else if (mag[31:15] != 17'd0)
				ilen = 3'd3;
			else if (mag[31:7] != 25'd0)
				ilen = 3'd2;
			else
				ilen = 3'd1;
		end else begin
			if (mag[31:24] != 8'd0)
				ilen = 3'd4;
			else if (mag[23:16] != 8'd0)
				ilen = 3'd3;
			else if (mag[15:8] != 8'd0)
				ilen = 3'd2;
			else
				ilen = 3'd1;
		end
		ibody = '0;
		case (ilen)
			3'd4: begin
				ibody[0] = lo[31:24];
				ibody[1] = lo[23:16];
				ibody[2] = lo[15:8];
				ibody[3] = lo[7:0];
			end
			3'd3: begin
				ibody[0] = lo[23:16];
				ibody[1] = lo[15:8];
				ibody[2] = lo[7:0];
			end
			3'd2: begin
				ibody[0] = lo[15:8];
				ibody[1] = lo[7:0];
			end
			default: begin
				ibody[0] = lo[7:0];
			end
		endcase
	end

	assign oid_word = {object_type[9:0], value[21:0]};
	assign year_byte = (year == YEAR_ANY) ? FIELD_ANY : 8'(year - YEAR_BASE);

	always_comb begin
		tag      = tag_number;
		cls      = CLASS_CTX;
		use_mark = 1'b0;
		mark     = 3'd0;
		clen     = 4'd0;
		body     = '0;
		bad      = 1'b0;
		unique case (action_t'(action))
			ACT_NULL: begin
				tag = TAG_NULL;
				cls = 8'd0;
			end
			ACT_BOOL: begin
				tag      = TAG_BOOL;
				cls      = 8'd0;
				use_mark = 1'b1;
				mark     = {2'b00, lo_nz};
			end
			ACT_UNS, ACT_ENUM, ACT_SGN: begin
				tag  = (action_t'(action) == ACT_UNS) ? TAG_UNS :
				       (action_t'(action) == ACT_ENUM) ? TAG_ENUM : TAG_SGN;
				cls  = 8'd0;
				clen = {1'b0, ilen};
				body = ibody;
			end
			ACT_REAL: begin
				tag  = TAG_REAL;
				cls  = 8'd0;
				clen = 4'd4;
				bad  = ({1'b0, lo[30:0]} > REAL_INF);
				body[0] = lo[31:24];
				body[1] = lo[23:16];
				body[2] = lo[15:8];
				body[3] = lo[7:0];
			end
			ACT_DBL: begin
				tag  = TAG_DBL;
				cls  = 8'd0;
				clen = 4'd8;
				bad  = (value[62:0] > DBL_INF);
				for (int i = 0; i < 8; i++) begin
					body[i] = value[8*(7-i) +: 8];
				end
			end
			ACT_DATE: begin
				tag  = TAG_DATE;
				cls  = 8'd0;
				clen = 4'd4;
				bad  = !((year == YEAR_ANY) || (year >= YEAR_BASE && year <= YEAR_MAX)) ||
				       !((byte_b >= 8'd1 && byte_b <= 8'd14) || byte_b == FIELD_ANY) ||
				       !((byte_c >= 8'd1 && byte_c <= 8'd34) || byte_c == FIELD_ANY) ||
				       !((byte_d >= 8'd1 && byte_d <= 8'd7) || byte_d == FIELD_ANY);
				body[0] = year_byte;
				body[1] = byte_b;
				body[2] = byte_c;
				body[3] = byte_d;
			end
			ACT_TIME: begin
				tag  = TAG_TIME;
				cls  = 8'd0;
				clen = 4'd4;
				bad  = !(byte_a <= 8'd23 || byte_a == FIELD_ANY) ||
				       !(byte_b <= 8'd59 || byte_b == FIELD_ANY) ||
				       !(byte_c <= 8'd59 || byte_c == FIELD_ANY) ||
				       !(byte_d <= 8'd99 || byte_d == FIELD_ANY);
				body[0] = byte_a;
				body[1] = byte_b;
				body[2] = byte_c;
				body[3] = byte_d;
			end
			ACT_OID: begin
				tag  = TAG_OID;
				cls  = 8'd0;
				clen = 4'd4;
				bad  = (object_type > OTYPE_MAX) || (value[63:22] != 42'd0);
				body[0] = oid_word[31:24];
				body[1] = oid_word[23:16];
				body[2] = oid_word[15:8];
				body[3] = oid_word[7:0];
			end
			ACT_CTX_UNS, ACT_CTX_ENUM, ACT_CTX_SGN: begin
				bad  = (tag_number == TAG_REFUSED);
				clen = {1'b0, ilen};
				body = ibody;
			end
			ACT_CTX_BOOL: begin
				bad     = (tag_number == TAG_REFUSED);
				clen    = 4'd1;
				body[0] = {7'd0, lo_nz};
			end
			ACT_OPEN: begin
				bad      = (tag_number == TAG_REFUSED);
				use_mark = 1'b1;
				mark     = MARK_OPEN;
			end
			ACT_CLOSE: begin
				bad      = (tag_number == TAG_REFUSED);
				use_mark = 1'b1;
				mark     = MARK_CLOSE;
			end
			default: begin
				bad = 1'b1;
			end
		endcase
	end

	// Header: tag octet, then an extended tag number and an extended length if needed.
	assign ext_tag = (tag >= TAG_EXT_MIN);
	assign ext_len = !use_mark && (clen >= 4'd5);
	assign low3    = use_mark ? mark : (ext_len ? LEN_EXT : clen[2:0]);
	assign h0      = (ext_tag ? HDR_EXT_TAG : {tag[3:0], 4'h0}) | cls | {5'd0, low3};
	assign hlen    = 2'd1 + {1'b0, ext_tag} + {1'b0, ext_len};
	assign total   = {2'b00, hlen} + clen;

	always_comb begin
		rec.err    = bad || ({4'd0, total} > room);
		rec.total  = rec.err ? 4'd1 : total;
		rec.hlen   = hlen;
		rec.hdr[0] = h0;
		rec.hdr[1] = ext_tag ? tag : {4'd0, clen};
		rec.hdr[2] = {4'd0, clen};
		rec.body   = body;
	end

endmodule

`default_nettype wire

/* hw/rtl/bpve_queue.sv */
// Short queue of encoded records between the front end and the serialiser.
// Register based, one push and one pop per cycle. Depends on bpve_pkg.
`default_nettype none

module bpve_queue import bpve_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire rec_t push_rec,
	input  wire logic pop,
	output rec_t      pop_rec,
	output logic      full,
	output logic      empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rec_t            mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign pop_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue read while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not advance on a lone push");

endmodule

`default_nettype wire

/* hw/rtl/bpve_back.sv */
// Serialiser of the BACnet primitive value encoder: emits one octet of a record per cycle.
// Takes records from bpve_queue. Depends on bpve_pkg.
`default_nettype none

module bpve_back import bpve_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire rec_t next_rec,
	input  wire logic next_avail,
	output logic      take,
	output logic      strobe,
	output logic [7:0] out_byte,
	output logic      last,
	output logic      error
);

	rec_t       cur_q;
	logic       active_q;
	logic [3:0] idx_q;
	logic [3:0] bidx;
	logic       finish;

	assign bidx   = idx_q - {2'b00, cur_q.hlen};
	assign finish = active_q && (idx_q == cur_q.total - 4'd1);
	// A new record is loaded in the cycle that the current one ends, so values follow without a gap.
	assign take   = next_avail && (!active_q || finish);

	assign strobe   = active_q;
	assign last     = finish;
	assign error    = active_q && cur_q.err;
	assign out_byte = (!active_q || cur_q.err) ? 8'd0 :
	                  (idx_q < {2'b00, cur_q.hlen}) ? cur_q.hdr[idx_q[1:0]] :
	                  cur_q.body[bidx[2:0]];

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= next_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (take) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (finish) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/bacnet_primitive_value_encoder.sv */
// BACnet primitive value encoder, top level: front end, record queue and serialiser.
// A value taken on start is queued, then loaded into the serialiser that sends its first octet.
// Output: a value of n octets (1 to 10; an error gives one) is sent as n strobed octets;
// queued values follow without gaps, the receiver cannot stall and busy rises only when the queue fills.
// Reset: arst_n clears the queue and the serialiser at once; no results are pending after it.
// Depends on bpve_pkg, bpve_front, bpve_queue and bpve_back.
`default_nettype none

module bacnet_primitive_value_encoder import bpve_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [3:0]  action,
	input  wire logic [7:0]  tag_number,
	input  wire logic [63:0] value,
	input  wire logic [15:0] object_type,
	input  wire logic [15:0] year,
	input  wire logic [7:0]  byte_a,
	input  wire logic [7:0]  byte_b,
	input  wire logic [7:0]  byte_c,
	input  wire logic [7:0]  byte_d,
	input  wire logic [7:0]  room,
	output logic             strobe,
	output logic [7:0]       out_byte,
	output logic             last,
	output logic             error
);

	rec_t front_rec;
	rec_t queue_rec;
	logic queue_full;
	logic queue_empty;
	logic take;
	logic push;

	assign busy = queue_full;
	assign push = start && !queue_full;

	bpve_front u_front (
		.action      (action),
		.tag_number  (tag_number),
		.value       (value),
		.object_type (object_type),
		.year        (year),
		.byte_a      (byte_a),
		.byte_b      (byte_b),
		.byte_c      (byte_c),
		.byte_d      (byte_d),
		.room        (room),
		.rec         (front_rec)
	);

	bpve_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (front_rec),
		.pop      (take),
		.pop_rec  (queue_rec),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	bpve_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.next_rec   (queue_rec),
		.next_avail (!queue_empty),
		.take       (take),
		.strobe     (strobe),
		.out_byte   (out_byte),
		.last       (last),
		.error      (error)
	);

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for bacnet_primitive_value_encoder: directed values, then random ones.
// Depends on bpve_pkg and the encoder RTL; expected octets come from a predictor kept here.

module tb;
	import bpve_pkg::*;

	localparam int LIMIT = 200000;
	localparam logic [63:0] INST_MAX = 64'h3F_FFFF;

	typedef struct {
		action_t     act;
		logic [7:0]  tag;
		logic [63:0] val;
		logic [15:0] otype;
		logic [15:0] year;
		logic [7:0]  ba, bb, bc, bd;
		logic [7:0]  room;
	} value_req_t;

	typedef struct packed {
		logic [7:0] octet;
		logic       last;
		logic       err;
	} encoded_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [3:0]  action = '0;
	logic [7:0]  tag_number = '0;
	logic [63:0] value = '0;
	logic [15:0] object_type = '0;
	logic [15:0] year = '0;
	logic [7:0]  byte_a = '0, byte_b = '0, byte_c = '0, byte_d = '0;
	logic [7:0]  room = '0;
	logic        strobe;
	logic [7:0]  out_byte;
	logic        last;
	logic        error;

	encoded_word_t pending_words[$];
	encoded_word_t want;
	logic [7:0]    octets[$];
	int            failures = 0;
	int            cycles = 0;
	bit            gaps_on = 1'b1;

	bacnet_primitive_value_encoder dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .tag_number(tag_number), .value(value),
		.object_type(object_type), .year(year),
		.byte_a(byte_a), .byte_b(byte_b), .byte_c(byte_c), .byte_d(byte_d),
		.room(room), .strobe(strobe), .out_byte(out_byte), .last(last), .error(error)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("bacnet_primitive_value_encoder: mismatch");
			$finish;
		end
	end

	// Encoder model -------------------------------------------------------------------

	function automatic void put_header(input logic [7:0] tag, input logic [7:0] cls,
		input bit marked, input logic [2:0] mark, input int len);
		logic [7:0] first;
		first = ((tag < TAG_EXT_MIN) ? {tag[3:0], 4'h0} : HDR_EXT_TAG) | cls;
		if (marked)
			first = first | {5'd0, mark};
		else if (len < 5)
			first = first | 8'(len);
		else
			first = first | {5'd0, LEN_EXT};
		octets.push_back(first);
		if (tag >= TAG_EXT_MIN)
			octets.push_back(tag);
		if (!marked && len >= 5)
			octets.push_back(8'(len));
	endfunction

	function automatic void put_content(input logic [63:0] data, input int n);
		for (int i = 0; i < n; i++)
			octets.push_back(data[8*(n-1-i) +: 8]);
	endfunction

	// Integers take the fewest big-endian octets that still hold the value, sign included.
	function automatic void put_int(input logic [7:0] tag, input logic [7:0] cls,
		input logic [31:0] v, input bit sgn);
		logic [31:0] mag;
		int n;
		mag = (sgn && v[31]) ? ~v : v;
		n = 1;
		while (n < 4 && (mag >> (8*n - (sgn ? 1 : 0))) != 0)
			n++;
		put_header(tag, cls, 1'b0, 3'd0, n);
		put_content({32'd0, v}, n);
	endfunction

	function automatic void encode_value(input value_req_t r);
		logic [31:0] lo;
		logic [7:0]  yr;
		bit          bad;
		lo = r.val[31:0];
		bad = 1'b0;
		yr = 8'd0;
		octets.delete();
		case (r.act)
			ACT_NULL: put_header(TAG_NULL, 8'h00, 1'b0, 3'd0, 0);
			ACT_BOOL: put_header(TAG_BOOL, 8'h00, 1'b1, {2'b00, lo != 0}, 0);
			ACT_UNS:  put_int(TAG_UNS, 8'h00, lo, 1'b0);
			ACT_ENUM: put_int(TAG_ENUM, 8'h00, lo, 1'b0);
			ACT_SGN:  put_int(TAG_SGN, 8'h00, lo, 1'b1);
			ACT_REAL: begin
				if ({1'b0, lo[30:0]} > REAL_INF)
					bad = 1'b1;
				else begin
					put_header(TAG_REAL, 8'h00, 1'b0, 3'd0, 4);
					put_content({32'd0, lo}, 4);
				end
			end
			ACT_DBL: begin
				if (r.val[62:0] > DBL_INF)
					bad = 1'b1;
				else begin
					put_header(TAG_DBL, 8'h00, 1'b0, 3'd0, 8);
					put_content(r.val, 8);
				end
			end
			ACT_DATE: begin
				if (r.year == YEAR_ANY)
					yr = FIELD_ANY;
				else if (r.year >= YEAR_BASE && r.year <= YEAR_MAX)
					yr = 8'(r.year - YEAR_BASE);
				else
					bad = 1'b1;
				if (!((r.bb >= 1 && r.bb <= 14) || r.bb == FIELD_ANY))
					bad = 1'b1;
				if (!((r.bc >= 1 && r.bc <= 34) || r.bc == FIELD_ANY))
					bad = 1'b1;
				if (!((r.bd >= 1 && r.bd <= 7) || r.bd == FIELD_ANY))
					bad = 1'b1;
				if (!bad) begin
					put_header(TAG_DATE, 8'h00, 1'b0, 3'd0, 4);
					put_content({32'd0, yr, r.bb, r.bc, r.bd}, 4);
				end
			end
			ACT_TIME: begin
				if (!(r.ba <= 23 || r.ba == FIELD_ANY) || !(r.bb <= 59 || r.bb == FIELD_ANY) ||
					!(r.bc <= 59 || r.bc == FIELD_ANY) || !(r.bd <= 99 || r.bd == FIELD_ANY))
					bad = 1'b1;
				else begin
					put_header(TAG_TIME, 8'h00, 1'b0, 3'd0, 4);
					put_content({32'd0, r.ba, r.bb, r.bc, r.bd}, 4);
				end
			end
			ACT_OID: begin
				if (r.otype > OTYPE_MAX || r.val > INST_MAX)
					bad = 1'b1;
				else begin
					put_header(TAG_OID, 8'h00, 1'b0, 3'd0, 4);
					put_content({32'd0, r.otype[9:0], r.val[21:0]}, 4);
				end
			end
			default: begin
				if (r.tag == TAG_REFUSED)
					bad = 1'b1;
				else if (r.act == ACT_CTX_UNS || r.act == ACT_CTX_ENUM)
					put_int(r.tag, CLASS_CTX, lo, 1'b0);
				else if (r.act == ACT_CTX_SGN)
					put_int(r.tag, CLASS_CTX, lo, 1'b1);
				else if (r.act == ACT_CTX_BOOL) begin
					put_header(r.tag, CLASS_CTX, 1'b0, 3'd0, 1);
					put_content({63'd0, lo != 0}, 1);
				end else if (r.act == ACT_OPEN)
					put_header(r.tag, CLASS_CTX, 1'b1, MARK_OPEN, 0);
				else
					put_header(r.tag, CLASS_CTX, 1'b1, MARK_CLOSE, 0);
			end
		endcase
		if (!bad && octets.size() > r.room)
			bad = 1'b1;
		if (bad)
			pending_words.push_back('{octet: 8'h00, last: 1'b1, err: 1'b1});
		else
			for (int i = 0; i < octets.size(); i++)
				pending_words.push_back('{octet: octets[i], last: i == octets.size() - 1,
					err: 1'b0});
	endfunction

	// Checker: every strobed word is matched against the oldest expected one.
	always @(posedge clk) begin
		if (strobe === 1'b1) begin
			if (pending_words.size() == 0) begin
				$error("word with nothing expected: out_byte %02h last %b error %b",
					out_byte, last, error);
				failures++;
			end else begin
				want = pending_words.pop_front();
				if (out_byte !== want.octet) begin
					$error("out_byte: expected %02h, got %02h", want.octet, out_byte);
					failures++;
				end
				if (last !== want.last) begin
					$error("last: expected %b, got %b", want.last, last);
					failures++;
				end
				if (error !== want.err) begin
					$error("error: expected %b, got %b", want.err, error);
					failures++;
				end
			end
		end
	end

	// Driving -------------------------------------------------------------------------

	task automatic send_value(input value_req_t r);
		@(negedge clk);
		if (gaps_on)
			while ($urandom_range(0, 99) < 8) begin
				start <= 1'b0;
				@(negedge clk);
			end
		action <= r.act;
		tag_number <= r.tag;
		value <= r.val;
		object_type <= r.otype;
		year <= r.year;
		byte_a <= r.ba;
		byte_b <= r.bb;
		byte_c <= r.bc;
		byte_d <= r.bd;
		room <= r.room;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		encode_value(r);
	endtask

	task automatic release_start();
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic wait_for_results();
		release_start();
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	function automatic value_req_t base_req(input action_t a, input logic [63:0] v);
		value_req_t r;
		r.act = a;
		r.tag = 8'd0;
		r.val = v;
		r.otype = 16'd0;
		r.year = YEAR_ANY;
		r.ba = FIELD_ANY;
		r.bb = FIELD_ANY;
		r.bc = FIELD_ANY;
		r.bd = FIELD_ANY;
		r.room = 8'd255;
		return r;
	endfunction

	function automatic value_req_t ctx_req(input action_t a, input logic [7:0] tag,
		input logic [63:0] v);
		value_req_t r;
		r = base_req(a, v);
		r.tag = tag;
		return r;
	endfunction

	function automatic value_req_t random_req();
		value_req_t r;
		int unsigned n;
		logic [31:0] lo;
		r.act = action_t'($urandom_range(0, 15));
		r.val = {$urandom, $urandom};
		r.otype = 16'($urandom);
		r.year = 16'($urandom);
		r.ba = 8'($urandom);
		r.bb = 8'($urandom);
		r.bc = 8'($urandom);
		r.bd = 8'($urandom);
		n = $urandom_range(0, 9);
		r.tag = (n < 6) ? 8'($urandom_range(0, 14)) :
			(n < 9) ? 8'($urandom_range(15, 254)) : 8'($urandom);
		// Short integers are drawn often so that every encoded length comes up.
		n = $urandom_range(1, 4);
		lo = $urandom >> (8 * (4 - n));
		if ($urandom_range(0, 1))
			lo = ~lo;
		case (r.act)
			ACT_BOOL, ACT_CTX_BOOL:
				r.val[31:0] = $urandom_range(0, 2) == 0 ? 32'd0 : lo;
			ACT_UNS, ACT_ENUM, ACT_SGN, ACT_CTX_UNS, ACT_CTX_ENUM, ACT_CTX_SGN:
				r.val[31:0] = lo;
			ACT_REAL: begin
				n = $urandom_range(0, 5);
				if (n == 0)
					r.val[30:0] = {8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
				else if (n == 1)
					r.val[30:0] = REAL_INF[30:0];
			end
			ACT_DBL: begin
				n = $urandom_range(0, 5);
				if (n == 0)
					r.val[62:52] = 11'h7FF;
				else if (n == 1)
					r.val[62:0] = DBL_INF;
			end
			ACT_DATE: begin
				if ($urandom_range(0, 3) != 0) begin
					r.year = $urandom_range(0, 4) == 0 ? YEAR_ANY :
						16'($urandom_range(YEAR_BASE, YEAR_MAX));
					r.bb = $urandom_range(0, 4) == 0 ? FIELD_ANY : 8'($urandom_range(1, 14));
					r.bc = $urandom_range(0, 4) == 0 ? FIELD_ANY : 8'($urandom_range(1, 34));
					r.bd = $urandom_range(0, 4) == 0 ? FIELD_ANY : 8'($urandom_range(1, 7));
				end
			end
			ACT_TIME: begin
				if ($urandom_range(0, 3) != 0) begin
					r.ba = $urandom_range(0, 4) == 0 ? FIELD_ANY : 8'($urandom_range(0, 23));
					r.bb = $urandom_range(0, 4) == 0 ? FIELD_ANY : 8'($urandom_range(0, 59));
					r.bc = $urandom_range(0, 4) == 0 ? FIELD_ANY : 8'($urandom_range(0, 59));
					r.bd = $urandom_range(0, 4) == 0 ? FIELD_ANY : 8'($urandom_range(0, 99));
				end
			end
			ACT_OID: begin
				if ($urandom_range(0, 3) != 0) begin
					r.otype = 16'($urandom_range(0, 1023));
					r.val = {42'd0, 22'($urandom)};
				end
			end
			default: ;
		endcase
		r.room = $urandom_range(0, 6) == 0 ? 8'($urandom_range(0, 11)) :
			$urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(10, 255));
		return r;
	endfunction

	// Tests ---------------------------------------------------------------------------

	task automatic test_application_kinds();
		value_req_t r;
		send_value(base_req(ACT_NULL, 64'd0));
		send_value(base_req(ACT_BOOL, 64'hFFFF_FFFF_0000_0000));
		send_value(base_req(ACT_BOOL, 64'd1));
		send_value(base_req(ACT_UNS, 64'd0));
		send_value(base_req(ACT_UNS, 64'hFFFF_FFFF));
		send_value(base_req(ACT_ENUM, 64'h100));
		send_value(base_req(ACT_SGN, 64'h8000_0000));
		send_value(base_req(ACT_SGN, 64'hFFFF_FF80));
		send_value(base_req(ACT_SGN, 64'h80));
		// A NaN is refused whatever its sign; infinity is encoded.
		send_value(base_req(ACT_REAL, 64'hFFC0_0000));
		send_value(base_req(ACT_REAL, 64'h7F80_0000));
		send_value(base_req(ACT_DBL, 64'h7FF0_0000_0000_0001));
		send_value(base_req(ACT_DBL, 64'hFFF0_0000_0000_0000));
		r = base_req(ACT_DATE, 64'd0);
		r.year = YEAR_MAX;
		r.bb = 8'd14;
		r.bc = 8'd34;
		r.bd = 8'd7;
		send_value(r);
		r.year = YEAR_BASE - 16'd1;
		send_value(r);
		send_value(base_req(ACT_DATE, 64'd0));
		r = base_req(ACT_TIME, 64'd0);
		r.ba = 8'd23;
		r.bb = 8'd59;
		r.bc = 8'd59;
		r.bd = 8'd99;
		send_value(r);
		r.ba = 8'd24;
		send_value(r);
		r = base_req(ACT_OID, INST_MAX);
		r.otype = OTYPE_MAX;
		send_value(r);
		r.val = 64'h1_0000_0000;
		send_value(r);
	endtask

	task automatic test_context_kinds();
		send_value(ctx_req(ACT_CTX_UNS, 8'd254, 64'h1234_5678));
		send_value(ctx_req(ACT_CTX_SGN, 8'd14, 64'hFFFF_FFFF));
		send_value(ctx_req(ACT_CTX_BOOL, TAG_EXT_MIN, 64'd5));
		send_value(ctx_req(ACT_OPEN, 8'd0, 64'd0));
		send_value(ctx_req(ACT_CLOSE, TAG_REFUSED, 64'd0));
	endtask

	task automatic test_room_limit();
		value_req_t r;
		// A double needs ten octets: one short is refused, an exact fit is encoded.
		r = base_req(ACT_DBL, 64'h4009_21FB_5444_2D18);
		r.room = 8'd9;
		send_value(r);
		r.room = 8'd10;
		send_value(r);
		r = base_req(ACT_NULL, 64'd0);
		r.room = 8'd0;
		send_value(r);
	endtask

	task automatic test_random_values(input int count);
		for (int i = 0; i < count; i++)
			send_value(random_req());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_application_kinds();
		test_context_kinds();
		test_room_limit();
		test_random_values(150);
		// Let the encoder run dry before the next burst.
		wait_for_results();
		gaps_on = 1'b0;
		test_random_values(100);
		gaps_on = 1'b1;
		test_random_values(150);
		wait_for_results();
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("bacnet_primitive_value_encoder: match");
		else
			$display("bacnet_primitive_value_encoder: mismatch");
		$finish;
	end

endmodule
